>>> src/roi_pixel_mask_assert.svh
// Assertion macros used by the output stage (roi_skid) of the region-of-interest mask.
`ifndef ROI_PIXEL_MASK_ASSERT_SVH
`define ROI_PIXEL_MASK_ASSERT_SVH
`ifndef SYNTHESIS
`define ROI_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("roi_pixel_mask: implication check failed");
`define ROI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("roi_pixel_mask: next-cycle check failed");
`else
`define ROI_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ROI_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> src/roi_pkg.sv
// Types and constants shared by the region-of-interest mask modules.
`default_nettype none
package roi_pkg;

  localparam int COORD_BITS = 12;
  localparam int PIXEL_BITS = 32;
  localparam int FRAC_BITS_DEFAULT = 8;
  localparam int TRIG_FRAC = 14;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 24;
  localparam logic [15:0] COS_RESET = 16'd16384;

  typedef enum logic [1:0] {
    SHAPE_POINT   = 2'd0,
    SHAPE_RECT    = 2'd1,
    SHAPE_ROTATED = 2'd2
  } shape_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SHAPE_MODE = 3'd0,
    REG_CENTER_X   = 3'd1,
    REG_CENTER_Y   = 3'd2,
    REG_HALF_W     = 3'd3,
    REG_HALF_H     = 3'd4,
    REG_COS        = 3'd5,
    REG_SIN        = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]  shape_mode;
    logic [23:0] center_x;
    logic [23:0] center_y;
    logic [22:0] half_w;
    logic [22:0] half_h;
    logic [15:0] cos_q;
    logic [15:0] sin_q;
  } cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_col;
    logic [COORD_BITS-1:0] pixel_row;
    logic [PIXEL_BITS-1:0] pixel_value;
  } in_word_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] masked_value;
    logic                  inside_region;
    logic                  region_valid;
  } out_word_t;

endpackage
`default_nettype wire

>>> src/roi_cfg.sv
// Configuration register file of the region-of-interest mask.
`default_nettype none
module roi_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [roi_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [roi_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output roi_pkg::cfg_t                            cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shape_mode <= roi_pkg::SHAPE_POINT;
      cfg.center_x   <= '0;
      cfg.center_y   <= '0;
      cfg.half_w     <= '0;
      cfg.half_h     <= '0;
      cfg.cos_q      <= roi_pkg::COS_RESET;
      cfg.sin_q      <= '0;
    end else if (cfg_valid) begin
      case (roi_pkg::cfg_reg_t'(cfg_index))
        roi_pkg::REG_SHAPE_MODE: cfg.shape_mode <= cfg_data[1:0];
        roi_pkg::REG_CENTER_X:   cfg.center_x   <= cfg_data[23:0];
        roi_pkg::REG_CENTER_Y:   cfg.center_y   <= cfg_data[23:0];
        roi_pkg::REG_HALF_W:     cfg.half_w     <= cfg_data[22:0];
        roi_pkg::REG_HALF_H:     cfg.half_h     <= cfg_data[22:0];
        roi_pkg::REG_COS:        cfg.cos_q      <= cfg_data[15:0];
        roi_pkg::REG_SIN:        cfg.sin_q      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/roi_calc.sv
// Input register, projection products and region test of the mask.
`default_nettype none
module roi_calc #(
  parameter int FRAC_BITS = roi_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire logic               in_valid,
  input  wire roi_pkg::in_word_t  in_word,
  input  wire roi_pkg::cfg_t      cfg,
  output logic                    res_valid,
  output roi_pkg::out_word_t      res_word
);

  localparam int PW  = roi_pkg::COORD_BITS + FRAC_BITS;
  localparam int DW  = ((PW + 1 > 24) ? PW + 1 : 24) + 1;
  localparam int PRW = DW + 16;
  localparam int LW  = PRW + 1;
  localparam logic [24:0] HALF_C = 25'd1 << (FRAC_BITS - 1);

  logic                               s0_valid;
  roi_pkg::in_word_t                  s0_word;

  logic                               s1_valid;
  logic [roi_pkg::PIXEL_BITS-1:0]     s1_pixel;
  logic                               s1_region_valid;
  logic                               s1_rotated;
  logic                               s1_pre_inside;
  logic signed [PRW-1:0]              s1_p_xc;
  logic signed [PRW-1:0]              s1_p_ys;
  logic signed [PRW-1:0]              s1_p_yc;
  logic signed [PRW-1:0]              s1_p_xs;

  logic [PW-1:0]                      px;
  logic [PW-1:0]                      py;
  logic signed [DW-1:0]               pxs;
  logic signed [DW-1:0]               pys;
  logic signed [DW-1:0]               cxs;
  logic signed [DW-1:0]               cys;
  logic signed [DW-1:0]               hws;
  logic signed [DW-1:0]               hhs;
  logic signed [DW-1:0]               dx;
  logic signed [DW-1:0]               dy;
  logic signed [15:0]                 cs;
  logic signed [15:0]                 sn;
  logic signed [24:0]                 sx;
  logic signed [24:0]                 sy;
  logic signed [24:0]                 rnd_x;
  logic signed [24:0]                 rnd_y;
  logic                               point_x;
  logic                               point_y;
  logic                               rect_in;
  logic                               extents_ok;
  logic                               region_valid_next;
  logic                               pre_inside_next;

  logic signed [LW-1:0]               lx;
  logic signed [LW-1:0]               ly;
  logic signed [LW-1:0]               bw;
  logic signed [LW-1:0]               bh;
  logic                               rot_in;
  logic                               in_region;

  assign px  = {s0_word.pixel_col, 1'b1, {(FRAC_BITS - 1){1'b0}}};
  assign py  = {s0_word.pixel_row, 1'b1, {(FRAC_BITS - 1){1'b0}}};
  assign pxs = $signed({{(DW - PW){1'b0}}, px});
  assign pys = $signed({{(DW - PW){1'b0}}, py});
  assign cxs = DW'($signed(cfg.center_x));
  assign cys = DW'($signed(cfg.center_y));
  assign hws = DW'($signed({1'b0, cfg.half_w}));
  assign hhs = DW'($signed({1'b0, cfg.half_h}));
  assign dx  = pxs - cxs;
  assign dy  = pys - cys;
  assign cs  = $signed(cfg.cos_q);
  assign sn  = $signed(cfg.sin_q);

  // Point coordinates round half away from zero; a negative one can only match index zero.
  assign sx      = $signed({cfg.center_x[23], cfg.center_x}) + $signed(HALF_C);
  assign sy      = $signed({cfg.center_y[23], cfg.center_y}) + $signed(HALF_C);
  assign rnd_x   = sx >>> FRAC_BITS;
  assign rnd_y   = sy >>> FRAC_BITS;
  assign point_x = cfg.center_x[23]
                   ? (s0_word.pixel_col == '0) && !sx[24] && (sx != '0)
                   : ($unsigned(rnd_x) ==
                      {{(25 - roi_pkg::COORD_BITS){1'b0}}, s0_word.pixel_col});
  assign point_y = cfg.center_y[23]
                   ? (s0_word.pixel_row == '0) && !sy[24] && (sy != '0)
                   : ($unsigned(rnd_y) ==
                      {{(25 - roi_pkg::COORD_BITS){1'b0}}, s0_word.pixel_row});

  assign rect_in = (pxs >= cxs - hws) && (pxs < cxs + hws)
                   && (pys >= cys - hhs) && (pys < cys + hhs);

  assign extents_ok = (cfg.half_w != '0) && (cfg.half_h != '0);

  always_comb begin
    case (cfg.shape_mode)
      roi_pkg::SHAPE_POINT: begin
        region_valid_next = 1'b1;
        pre_inside_next   = point_x && point_y;
      end
      roi_pkg::SHAPE_RECT: begin
        region_valid_next = extents_ok;
        pre_inside_next   = rect_in;
      end
      roi_pkg::SHAPE_ROTATED: begin
        region_valid_next = extents_ok;
        pre_inside_next   = 1'b0;
      end
      default: begin
        region_valid_next = 1'b0;
        pre_inside_next   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
    end else if (advance) begin
      s0_valid <= in_valid;
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_word         <= in_word;
      s1_pixel        <= s0_word.pixel_value;
      s1_region_valid <= region_valid_next;
      s1_rotated      <= (cfg.shape_mode == roi_pkg::SHAPE_ROTATED);
      s1_pre_inside   <= pre_inside_next;
      s1_p_xc         <= PRW'(dx) * PRW'(cs);
      s1_p_ys         <= PRW'(dy) * PRW'(sn);
      s1_p_yc         <= PRW'(dy) * PRW'(cs);
      s1_p_xs         <= PRW'(dx) * PRW'(sn);
    end
  end

  assign lx = LW'(s1_p_xc) + LW'(s1_p_ys);
  assign ly = LW'(s1_p_yc) - LW'(s1_p_xs);
  assign bw = $signed(LW'({cfg.half_w, {roi_pkg::TRIG_FRAC{1'b0}}}));
  assign bh = $signed(LW'({cfg.half_h, {roi_pkg::TRIG_FRAC{1'b0}}}));

  assign rot_in    = (lx >= -bw) && (lx < bw) && (ly >= -bh) && (ly < bh);
  assign in_region = s1_region_valid && (s1_rotated ? rot_in : s1_pre_inside);

  assign res_valid              = s1_valid;
  assign res_word.masked_value  = in_region ? s1_pixel : '0;
  assign res_word.inside_region = in_region;
  assign res_word.region_valid  = s1_region_valid;

endmodule
`default_nettype wire

>>> src/roi_skid.sv
// Output register with a skid stage for the region-of-interest mask.
`default_nettype none
`include "roi_pixel_mask_assert.svh"
module roi_skid (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                res_valid,
  input  wire roi_pkg::out_word_t  res_word,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output roi_pkg::out_word_t       out_word,
  output logic                     advance
);

  logic               skid_valid;
  roi_pkg::out_word_t skid_word;
  logic               out_empty;

  assign advance = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!skid_valid) begin
      if (!out_valid || !out_stall) begin
        out_valid <= res_valid;
      end else if (res_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (!out_stall) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      if (!out_valid || !out_stall) begin
        out_word <= res_word;
      end else begin
        skid_word <= res_word;
      end
    end else if (!out_stall) begin
      out_word <= skid_word;
    end
  end

  assign out_empty = !out_word.inside_region && (out_word.masked_value == '0);

  `ROI_ASSERT_IMPL(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `ROI_ASSERT_NEXT(a_skid_drains, clk, rst, skid_valid && !out_stall, !skid_valid)
  `ROI_ASSERT_IMPL(a_invalid_zero, clk, rst, out_valid && !out_word.region_valid, out_empty)
  `ROI_ASSERT_IMPL(a_outside_zero, clk, rst, out_valid && !out_word.inside_region, out_empty)

endmodule
`default_nettype wire

>>> src/roi_pixel_mask.sv
// Top level of the region-of-interest pixel mask.
// Takes one pixel word per clock while in_stall is low and returns one word per
// pixel, in order. The path runs through an input register, a register after the
// four projection multipliers and an output register; a skid stage behind the
// output register holds one word, so in_stall rises only once both are full and
// is driven from a flop.
// Configuration writes are always ready and take effect at once.
`default_nettype none
module roi_pixel_mask #(
  parameter int FRAC_BITS = roi_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire roi_pkg::in_word_t                   in_word,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output roi_pkg::out_word_t                       out_word,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [roi_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [roi_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  roi_pkg::cfg_t      cfg;
  roi_pkg::out_word_t res_word;
  logic               res_valid;
  logic               advance;

  assign in_stall = !advance;

  roi_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  roi_calc #(
    .FRAC_BITS (FRAC_BITS)
  ) u_calc (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  roi_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_word  (res_word),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .advance   (advance)
  );

endmodule
`default_nettype wire
